// ===== hw/rtl/nrs_pkg.sv =====
package nrs_pkg;

    localparam int MAX_ENTRIES   = 64;
    localparam int KEY_BYTES     = 20;
    localparam int WORDS_PER_KEY = (KEY_BYTES + 7) / 8;
    localparam int WORD_W        = (WORDS_PER_KEY > 1) ? $clog2(WORDS_PER_KEY) : 1;
    localparam int IDX_W         = 6;
    localparam int LEN_W         = 7;
    localparam int DIST_W        = 31;
    localparam int TXT_W         = $clog2(KEY_BYTES + 1);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] OP_WRITE_TABLE = 2'd0;
    localparam logic [1:0] OP_WRITE_KEY   = 2'd1;
    localparam logic [1:0] OP_SEARCH      = 2'd2;

    localparam logic [1:0] FIELD_NUMBER  = 2'd0;
    localparam logic [1:0] FIELD_BRAND   = 2'd1;
    localparam logic [1:0] FIELD_MILEAGE = 2'd2;

    typedef struct packed {
        logic             en;
        logic [1:0]       sel;
        logic [IDX_W-1:0] entry;
        logic [1:0]       word;
        logic [63:0]      data;
    } wr_t;

    typedef struct packed {
        logic             compute;
        logic             shift;
        logic [1:0]       sel;
        logic [LEN_W-1:0] len;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_COMPUTE = 4'b0010,
        ST_MIN     = 4'b0100,
        ST_EMIT    = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/nrs_cell.sv =====
module nrs_cell
    import nrs_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [IDX_W-1:0]                  my_index,
    input  wr_t                               wr,
    input  cell_ctrl_t                        ctrl,
    input  logic [WORDS_PER_KEY-1:0][63:0]    key_words,
    input  logic [63:0]                       mileage_key,
    input  logic [DIST_W-1:0]                 dist_in,
    input  logic                              vld_in,
    output logic [DIST_W-1:0]                 dist_out,
    output logic                              vld_out
);

    logic [WORDS_PER_KEY-1:0][63:0] number_reg;
    logic [WORDS_PER_KEY-1:0][63:0] brand_reg;
    logic [DIST_W-1:0]              mileage_reg;
    logic [DIST_W-1:0]              dist_reg;
    logic                           vld_reg;

    logic [WORDS_PER_KEY-1:0][63:0] rec;
    logic [KEY_BYTES-1:0]           diff_bytes;
    logic [TXT_W-1:0]               txt_dist;
    logic [63:0]                    abs_diff;
    logic [DIST_W-1:0]              mil_dist;
    logic [DIST_W-1:0]              dist_next;
    logic                           hit;

    assign hit = wr.en && (wr.entry == my_index);
    assign rec = (ctrl.sel == FIELD_NUMBER) ? number_reg : brand_reg;

    genvar k;
    generate
        for (k = 0; k < KEY_BYTES; k++) begin : g_byte
            assign diff_bytes[k] = rec[k / 8][8 * (k % 8) +: 8]
                                   != key_words[k / 8][8 * (k % 8) +: 8];
        end
    endgenerate

    assign txt_dist = TXT_W'($countones(diff_bytes));

    always_comb
    begin
        if (mileage_key >= {{(64 - DIST_W){1'b0}}, mileage_reg})
            abs_diff = mileage_key - {{(64 - DIST_W){1'b0}}, mileage_reg};
        else
            abs_diff = {{(64 - DIST_W){1'b0}}, mileage_reg} - mileage_key;
        mil_dist = (abs_diff > {{(64 - DIST_W){1'b0}}, DIST_MAX}) ? DIST_MAX
                                                                 : abs_diff[DIST_W-1:0];
        if (ctrl.sel == FIELD_MILEAGE)
            dist_next = mil_dist;
        else
            dist_next = {{(DIST_W - TXT_W){1'b0}}, txt_dist};
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            if (wr.sel == FIELD_MILEAGE)
                mileage_reg <= wr.data[DIST_W-1:0];
            else if (wr.sel == FIELD_NUMBER && wr.word < 2'(WORDS_PER_KEY))
                number_reg[wr.word[WORD_W-1:0]] <= wr.data;
            else if (wr.sel == FIELD_BRAND && wr.word < 2'(WORDS_PER_KEY))
                brand_reg[wr.word[WORD_W-1:0]] <= wr.data;
        end
        if (ctrl.compute)
            dist_reg <= dist_next;
        else if (ctrl.shift)
            dist_reg <= dist_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctrl.compute)
            vld_reg <= {1'b0, my_index} < ctrl.len;
        else if (ctrl.shift)
            vld_reg <= vld_in;
    end

    assign dist_out = dist_reg;
    assign vld_out  = vld_reg;

endmodule

// ===== hw/rtl/nearest_record_search.sv =====
// Writes give no result.
// A search computes every distance in the cell row, then rotates the row past
// the minimum tracker, then rotates it once more past the output register,
// where an output stall holds the rotation.
// An empty table or a bad field is answered on the accept, seen in the next cycle.
// Reset clears control state, the table length and the key words; records are undefined.
module nearest_record_search
    import nrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [1:0]         field_sel,
    input  logic [IDX_W-1:0]   entry_index,
    input  logic [1:0]         word_index,
    input  logic [63:0]        data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   match_index,
    output logic [DIST_W-1:0]  distance,
    output logic               found,
    output logic               is_last
);

    state_t                         state_reg, state_next;
    logic [LEN_W-1:0]               len_reg;
    logic [WORDS_PER_KEY-1:0][63:0] key_reg;
    logic [63:0]                    mkey_reg;
    logic [1:0]                     sel_reg;
    logic [IDX_W-1:0]               cnt_reg;
    logic [DIST_W-1:0]              best_reg;
    logic [IDX_W-1:0]               last_reg;
    logic                           ov_reg;
    logic [IDX_W-1:0]               oidx_reg;
    logic [DIST_W-1:0]              odist_reg;
    logic                           ofound_reg;
    logic                           olast_reg;

    wr_t                            wr;
    cell_ctrl_t                     ctrl;
    logic [DIST_W-1:0]              dist_chain [MAX_ENTRIES];
    logic                           vld_chain  [MAX_ENTRIES];
    logic                           accept;
    logic                           out_free;
    logic                           advance;
    logic                           emit_hit;
    logic                           empty_search;
    logic                           cnt_end;

    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && opcode == OP_SEARCH);
    assign accept   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign advance  = (state_reg == ST_EMIT) && out_free;
    assign emit_hit = advance && vld_chain[0] && (dist_chain[0] == best_reg);
    assign cnt_end  = cnt_reg == IDX_W'(MAX_ENTRIES - 1);
    assign empty_search = accept && opcode == OP_SEARCH
                          && (len_reg == '0 || field_sel == 2'd3);

    assign wr.en    = accept && opcode == OP_WRITE_TABLE;
    assign wr.sel   = field_sel;
    assign wr.entry = entry_index;
    assign wr.word  = word_index;
    assign wr.data  = data;

    assign ctrl.compute = state_reg == ST_COMPUTE;
    assign ctrl.shift   = (state_reg == ST_MIN) || advance;
    assign ctrl.sel     = sel_reg;
    assign ctrl.len     = len_reg;

    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
            nrs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .my_index    (IDX_W'(i)),
                .wr          (wr),
                .ctrl        (ctrl),
                .key_words   (key_reg),
                .mileage_key (mkey_reg),
                .dist_in     (dist_chain[(i + 1) % MAX_ENTRIES]),
                .vld_in      (vld_chain[(i + 1) % MAX_ENTRIES]),
                .dist_out    (dist_chain[i]),
                .vld_out     (vld_chain[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && opcode == OP_SEARCH && !empty_search)
                    state_next = ST_COMPUTE;
            ST_COMPUTE:
                state_next = ST_MIN;
            ST_MIN:
                if (cnt_end)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (advance && cnt_end)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            key_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                len_reg <= cfg_data;
            if (accept && opcode == OP_WRITE_KEY && word_index < 2'(WORDS_PER_KEY))
                key_reg[word_index[WORD_W-1:0]] <= data;
            if (state_reg == ST_COMPUTE)
                cnt_reg <= '0;
            else if (ctrl.shift)
                cnt_reg <= cnt_reg + 1'b1;
            if (empty_search || emit_hit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_SEARCH)
        begin
            sel_reg  <= field_sel;
            mkey_reg <= data;
        end
        if (state_reg == ST_COMPUTE)
        begin
            best_reg <= DIST_MAX;
            last_reg <= '0;
        end
        else if (state_reg == ST_MIN && vld_chain[0])
        begin
            // track the least distance and the last index that reaches it
            if (dist_chain[0] < best_reg)
            begin
                best_reg <= dist_chain[0];
                last_reg <= cnt_reg;
            end
            else if (dist_chain[0] == best_reg)
                last_reg <= cnt_reg;
        end
        if (empty_search)
        begin
            oidx_reg   <= '0;
            odist_reg  <= '0;
            ofound_reg <= 1'b0;
            olast_reg  <= 1'b1;
        end
        else if (emit_hit)
        begin
            oidx_reg   <= cnt_reg;
            odist_reg  <= best_reg;
            ofound_reg <= 1'b1;
            olast_reg  <= cnt_reg == last_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign match_index = oidx_reg;
    assign distance    = odist_reg;
    assign found       = ofound_reg;
    assign is_last     = olast_reg;

endmodule

// ===== hw/rtl/nrs_checker.sv =====
module nrs_assert
    import nrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [IDX_W-1:0]  match_index,
    input  logic [DIST_W-1:0] distance,
    input  logic              found,
    input  logic              is_last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(distance) && $stable(match_index))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> is_last)
        else $error("no-match result not marked last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> distance == '0 && match_index == '0)
        else $error("no-match result carries data");

endmodule

bind nearest_record_search nrs_assert u_nrs_assert (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_index (match_index),
    .distance    (distance),
    .found       (found),
    .is_last     (is_last)
);

// ===== test/nrs_checker.sv =====
module nrs_checker
    import nrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [1:0]        field_sel,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [1:0]        word_index,
    input  logic [63:0]       data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [IDX_W-1:0]  match_index,
    input  logic [DIST_W-1:0] distance,
    input  logic              found,
    input  logic              is_last,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] mdist;
        logic              hit;
        logic              last;
    } match_t;

    match_t            pending_matches[$];
    logic [63:0]       number_mem[MAX_ENTRIES][WORDS_PER_KEY];
    logic [63:0]       brand_mem[MAX_ENTRIES][WORDS_PER_KEY];
    logic [DIST_W-1:0] mileage_mem[MAX_ENTRIES];
    logic [63:0]       key_mem[WORDS_PER_KEY];
    logic [LEN_W-1:0]  record_count;

    assign pending = pending_matches.size();

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic logic [DIST_W-1:0] byte_mismatches(logic [63:0] rec[WORDS_PER_KEY]);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int k = 0; k < KEY_BYTES; k++)
            if (rec[k / 8][8 * (k % 8) +: 8] != key_mem[k / 8][8 * (k % 8) +: 8])
                n++;
        return n;
    endfunction

    // Queue every record at the least distance, else one no-match result
    task automatic predict_search(logic [1:0] sel, logic [63:0] key);
        logic [DIST_W-1:0] entry_dist[MAX_ENTRIES];
        logic [DIST_W-1:0] best;
        logic [63:0]       diff;
        int                len;
        int                last_hit;
        match_t            m;
        len = (record_count > MAX_ENTRIES) ? MAX_ENTRIES : record_count;
        if (len == 0 || sel == 2'd3) begin
            m = '{idx: '0, mdist: '0, hit: 1'b0, last: 1'b1};
            pending_matches.push_back(m);
            return;
        end
        best = DIST_MAX;
        for (int i = 0; i < len; i++) begin
            if (sel == FIELD_NUMBER)
                entry_dist[i] = byte_mismatches(number_mem[i]);
            else if (sel == FIELD_BRAND)
                entry_dist[i] = byte_mismatches(brand_mem[i]);
            else begin
                diff = (key >= 64'(mileage_mem[i])) ? key - 64'(mileage_mem[i])
                                                   : 64'(mileage_mem[i]) - key;
                entry_dist[i] = (diff > 64'(DIST_MAX)) ? DIST_MAX : diff[DIST_W-1:0];
            end
            if (entry_dist[i] < best)
                best = entry_dist[i];
        end
        last_hit = 0;
        for (int i = 0; i < len; i++)
            if (entry_dist[i] == best)
                last_hit = i;
        for (int i = 0; i < len; i++)
            if (entry_dist[i] == best) begin
                m = '{idx: IDX_W'(i), mdist: best, hit: 1'b1, last: i == last_hit};
                pending_matches.push_back(m);
            end
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        match_t m;
        if (!rst_n) begin
            record_count = '0;
            for (int w = 0; w < WORDS_PER_KEY; w++)
                key_mem[w] = '0;
            pending_matches.delete();
        end else begin
            if (cfg_we)
                record_count = cfg_data;
            if (out_valid && !out_stall) begin
                if (pending_matches.size() == 0) begin
                    $display("%0t: unexpected result transfer, index %0d", $realtime,
                             match_index);
                    errors++;
                end else begin
                    m = pending_matches.pop_front();
                    if (match_index !== m.idx) report("match_index", match_index, m.idx);
                    if (distance !== m.mdist)  report("distance", distance, m.mdist);
                    if (found !== m.hit)       report("found", found, m.hit);
                    if (is_last !== m.last)    report("is_last", is_last, m.last);
                end
            end
            if (in_valid && !in_stall) begin
                case (opcode)
                    OP_WRITE_TABLE:
                        if (field_sel == FIELD_MILEAGE)
                            mileage_mem[entry_index] = data[DIST_W-1:0];
                        else if (word_index < WORDS_PER_KEY) begin
                            if (field_sel == FIELD_NUMBER)
                                number_mem[entry_index][word_index] = data;
                            else if (field_sel == FIELD_BRAND)
                                brand_mem[entry_index][word_index] = data;
                        end
                    OP_WRITE_KEY:
                        if (word_index < WORDS_PER_KEY)
                            key_mem[word_index] = data;
                    OP_SEARCH:
                        predict_search(field_sel, data);
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb.sv =====
module tb
    import nrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [1:0] FIELD_BAD  = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        opcode;
    logic [1:0]        field_sel;
    logic [IDX_W-1:0]  entry_index;
    logic [1:0]        word_index;
    logic [63:0]       data;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] distance;
    logic              found;
    logic              is_last;
    int                errors;
    int                pending;
    logic              idling_on;
    int                hold_cycles;
    int                quiet_cycles;
    int                filled;

    nearest_record_search dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .field_sel(field_sel), .entry_index(entry_index), .word_index(word_index),
        .data(data), .out_valid(out_valid), .out_stall(out_stall),
        .match_index(match_index), .distance(distance), .found(found),
        .is_last(is_last)
    );

    nrs_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .field_sel(field_sel), .entry_index(entry_index), .word_index(word_index),
        .data(data), .out_valid(out_valid), .out_stall(out_stall),
        .match_index(match_index), .distance(distance), .found(found),
        .is_last(is_last), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0) begin
            out_stall = 1'b1;
            hold_cycles--;
        end else
            out_stall = idling_on && ($urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else if (rst_n && ++quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send(logic [1:0] op, logic [1:0] sel, logic [IDX_W-1:0] entry,
                        logic [1:0] word, logic [63:0] value);
        if (idling_on && $urandom_range(99) < 6) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid    = 1'b1;
        opcode      = op;
        field_sel   = sel;
        entry_index = entry;
        word_index  = word;
        data        = value;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Bytes mostly from a two-letter alphabet so that distances tie often
    function automatic logic [63:0] text_word();
        logic [63:0] w;
        if ($urandom_range(9) == 0)
            return {$urandom, $urandom};
        for (int b = 0; b < 8; b++)
            w[8 * b +: 8] = 8'h41 + 8'($urandom_range(1));
        return w;
    endfunction

    function automatic logic [63:0] mileage_value();
        if ($urandom_range(4) == 0)
            return {$urandom, $urandom};
        return 64'($urandom_range(6));
    endfunction

    task automatic write_record(int i);
        for (int w = 0; w < WORDS_PER_KEY; w++) begin
            send(OP_WRITE_TABLE, FIELD_NUMBER, IDX_W'(i), 2'(w), text_word());
            send(OP_WRITE_TABLE, FIELD_BRAND, IDX_W'(i), 2'(w), text_word());
        end
        send(OP_WRITE_TABLE, FIELD_MILEAGE, IDX_W'(i), 2'd0, mileage_value());
    endtask

    // Hold off until the block is idle again before touching the length
    task automatic set_length(int len);
        in_valid = 1'b0;
        while (pending != 0 || in_stall) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = LEN_W'(len);
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            send(OP_SEARCH, 2'($urandom_range(2)), '0, '0, mileage_value());
        else if (pick < 45)
            send(OP_WRITE_KEY, 2'($urandom_range(3)), '0, 2'($urandom_range(2)),
                 text_word());
        else if (pick < 85) begin
            // overwrite a record that is already whole, so it stays defined
            send(OP_WRITE_TABLE, 2'($urandom_range(2)), IDX_W'($urandom_range(filled - 1)),
                 2'($urandom_range(2)), $urandom_range(1) ? text_word() : mileage_value());
        end else begin
            case ($urandom_range(3))
                0: send(OP_IGNORED, 2'($urandom), 6'($urandom), 2'($urandom),
                        {$urandom, $urandom});
                1: send(OP_WRITE_TABLE, 2'($urandom_range(1)), 6'($urandom), 2'd3,
                        {$urandom, $urandom});
                2: send(OP_WRITE_TABLE, FIELD_BAD, 6'($urandom), 2'($urandom),
                        {$urandom, $urandom});
                default: send(OP_SEARCH, FIELD_BAD, 6'($urandom), 2'($urandom),
                              {$urandom, $urandom});
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = '0;
        field_sel = '0;
        entry_index = '0;
        word_index = '0;
        data = '0;
        out_stall = 1'b0;
        idling_on = 1'b1;
        hold_cycles = 0;
        quiet_cycles = 0;
        filled = 16;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, bad selector and ignored items, then fill the table and run directed searches
        set_length(0);
        send(OP_SEARCH, FIELD_NUMBER, '0, '0, '0);
        send(OP_SEARCH, FIELD_MILEAGE, '0, '0, '1);
        send(OP_IGNORED, FIELD_NUMBER, '0, '0, '1);
        send(OP_WRITE_KEY, FIELD_BAD, '0, 2'd3, '1);
        for (int i = 0; i < filled; i++)
            write_record(i);
        send(OP_WRITE_TABLE, FIELD_BAD, 6'd63, 2'd0, '1);
        send(OP_WRITE_TABLE, FIELD_NUMBER, 6'd0, 2'd3, '1);
        set_length(1);
        send(OP_SEARCH, FIELD_NUMBER, '0, '0, '0);
        send(OP_SEARCH, FIELD_BAD, '0, '0, '0);
        set_length(filled);
        for (int w = 0; w < WORDS_PER_KEY; w++)
            send(OP_WRITE_KEY, FIELD_NUMBER, '0, 2'(w), '1);
        send(OP_SEARCH, FIELD_NUMBER, '0, '0, '0);
        send(OP_SEARCH, FIELD_BRAND, '0, '0, '0);
        send(OP_SEARCH, FIELD_MILEAGE, '0, '0, '0);
        send(OP_SEARCH, FIELD_MILEAGE, '0, '0, '1);
        send(OP_SEARCH, FIELD_MILEAGE, '0, '0, 64'h0000_0000_7FFF_FFFF);
        send(OP_SEARCH, FIELD_MILEAGE, '0, '0, 64'h0000_0000_8000_0003);

        for (int phase = 0; phase < 5; phase++) begin
            set_length((phase == 0) ? filled : $urandom_range(filled));
            idling_on = (phase != 2);
            if (phase == 1)
                hold_cycles = 400;
            repeat ((phase == 2) ? 40 : 15) random_item();
        end
        idling_on = 1'b1;

        // fill the rest of the table with mileages only and search on mileage
        for (int i = filled; i < MAX_ENTRIES; i++)
            send(OP_WRITE_TABLE, FIELD_MILEAGE, IDX_W'(i), 2'd0, mileage_value());
        set_length(MAX_ENTRIES);
        repeat (6) send(OP_SEARCH, FIELD_MILEAGE, '0, '0, mileage_value());
        set_length(127);
        repeat (6) send(OP_SEARCH, FIELD_MILEAGE, '0, '0, mileage_value());
        set_length(100);
        repeat (6) send(OP_SEARCH, FIELD_MILEAGE, '0, '0, mileage_value());

        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/nrs_pkg.sv
hw/rtl/nrs_cell.sv
hw/rtl/nearest_record_search.sv
hw/rtl/nrs_checker.sv
test/nrs_checker.sv
test/tb.sv
